// ===== src/top_k_candidate_retention_top_defines.svh =====
// Assertion macros shared by the top-k candidate retention RTL.
// Every macro expects a clock named clock and a synchronous reset named reset in scope.
`ifndef TOP_K_CANDIDATE_RETENTION_TOP_DEFINES_SVH
`define TOP_K_CANDIDATE_RETENTION_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TKCR_ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tkcr assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TKCR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tkcr assertion failed");

`endif

// ===== src/tkcr_pkg.sv =====
// Shared types, constants and ranking functions of the top-k candidate retention block.
// No dependencies; every module of the block imports this package.
package tkcr_pkg;

   localparam int KEEP_DEPTH_DEF    = 16;
   localparam int SCORE_BITS        = 48;
   localparam int FRAC_BITS         = 31;
   localparam int METRIC_BITS       = SCORE_BITS + 1;
   localparam int COMPOSITE_DIVISOR = 16;
   localparam int COMP_SHIFT        = $clog2(COMPOSITE_DIVISOR);
   localparam int MODE_BITS         = 2;
   localparam int LIMIT_BITS        = 5;
   localparam int CSR_INDEX_BITS    = 2;

   localparam logic OP_OFFER = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic [MODE_BITS-1:0] METRIC_RANK      = 2'd0;
   localparam logic [MODE_BITS-1:0] METRIC_POWER     = 2'd1;
   localparam logic [MODE_BITS-1:0] METRIC_COMPOSITE = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_METRIC_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEEP_LIMIT  = 2'd1;

   localparam logic [MODE_BITS-1:0]  MODE_RESET  = METRIC_COMPOSITE;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;

   typedef struct packed {
      logic                         opcode;
      logic [FRAC_BITS-1:0]         numerator;
      logic [FRAC_BITS-1:0]         denominator;
      logic signed [SCORE_BITS-1:0] rank_score;
      logic signed [SCORE_BITS-1:0] power_score;
      logic signed [SCORE_BITS-1:0] held_rank_score;
      logic signed [SCORE_BITS-1:0] held_power_score;
   } req_type;

   typedef struct packed {
      logic [FRAC_BITS-1:0]         out_numerator;
      logic [FRAC_BITS-1:0]         out_denominator;
      logic signed [SCORE_BITS-1:0] out_rank_score;
      logic signed [SCORE_BITS-1:0] out_power_score;
      logic signed [SCORE_BITS-1:0] out_held_rank;
      logic signed [SCORE_BITS-1:0] out_held_power;
      logic                         store_empty;
      logic                         last_entry;
   } rsp_type;

   // One retained candidate, with its composite metric and tie key worked out on entry.
   typedef struct packed {
      logic [FRAC_BITS-1:0]   num;
      logic [FRAC_BITS-1:0]   den;
      logic [SCORE_BITS-1:0]  rank;
      logic [SCORE_BITS-1:0]  power;
      logic [SCORE_BITS-1:0]  hrank;
      logic [SCORE_BITS-1:0]  hpower;
      logic [METRIC_BITS-1:0] comp;
      logic [FRAC_BITS-1:0]   maxk;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_OFFER,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        in_range;
      logic        at_last;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

   function automatic logic [METRIC_BITS-1:0] metric_of(input logic [MODE_BITS-1:0] mode,
                                                         input entry_type e);
      logic [METRIC_BITS-1:0] m;
      case (mode)
         METRIC_RANK:  m = {{(METRIC_BITS-SCORE_BITS){e.rank[SCORE_BITS-1]}}, e.rank};
         METRIC_POWER: m = {{(METRIC_BITS-SCORE_BITS){e.power[SCORE_BITS-1]}}, e.power};
         default:      m = e.comp;
      endcase
      return m;
   endfunction

   // True when a ranks strictly above b.
   function automatic logic ranks_above(input logic [MODE_BITS-1:0] mode,
                                        input entry_type a, input entry_type b);
      logic signed [METRIC_BITS-1:0] ma;
      logic signed [METRIC_BITS-1:0] mb;
      logic                          r;
      ma = $signed(metric_of(mode, a));
      mb = $signed(metric_of(mode, b));
      if (ma != mb) begin
         r = ma > mb;
      end else if (a.maxk != b.maxk) begin
         r = a.maxk < b.maxk;
      end else if (a.den != b.den) begin
         r = a.den < b.den;
      end else begin
         r = a.num < b.num;
      end
      return r;
   endfunction

endpackage

// ===== src/tkcr_prep.sv =====
// Candidate stage: registers an offered item and works out its composite metric and tie key.
// Depends on tkcr_pkg.
module tkcr_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  tkcr_pkg::req_type   item,
   output tkcr_pkg::entry_type cand,
   output logic                cand_valid
);
   import tkcr_pkg::*;

   entry_type              cand_ff, cand_in;
   logic                   cand_valid_ff, cand_valid_in;
   logic [SCORE_BITS-1:0]  q_shift;
   logic                   q_round;
   logic [METRIC_BITS-1:0] sum;
   logic [METRIC_BITS-1:0] comp;

   // Division by the composite divisor truncates toward zero: round a negative quotient up.
   always_comb begin
      q_shift = SCORE_BITS'($signed(item.power_score) >>> COMP_SHIFT);
      q_round = item.power_score[SCORE_BITS-1] && (item.power_score[COMP_SHIFT-1:0] != '0);
      sum     = {{(METRIC_BITS-SCORE_BITS){item.rank_score[SCORE_BITS-1]}}, item.rank_score}
              + {{(METRIC_BITS-SCORE_BITS){q_shift[SCORE_BITS-1]}}, q_shift}
              + METRIC_BITS'(q_round);
      comp = sum;
      // For scores of 64 bits or more, the sum saturates to the signed score-width range.
      if ((METRIC_BITS > 64) && (sum[METRIC_BITS-1] != sum[METRIC_BITS-2])) begin
         comp = {sum[METRIC_BITS-1], sum[METRIC_BITS-1], {(METRIC_BITS-2){~sum[METRIC_BITS-1]}}};
      end
   end

   always_comb begin
      cand_in.num    = item.numerator;
      cand_in.den    = item.denominator;
      cand_in.rank   = item.rank_score;
      cand_in.power  = item.power_score;
      cand_in.hrank  = item.held_rank_score;
      cand_in.hpower = item.held_power_score;
      cand_in.comp   = comp;
      cand_in.maxk   = (item.numerator > item.denominator) ? item.numerator : item.denominator;
      cand_valid_in  = load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
      end else begin
         cand_valid_ff <= cand_valid_in;
      end
      if (load) begin
         cand_ff <= cand_in;
      end
   end

   assign cand       = cand_ff;
   assign cand_valid = cand_valid_ff;

endmodule

// ===== src/tkcr_cell.sv =====
// One cell of the sorted retention chain: holds one entry and trades it with its neighbors.
// Depends on tkcr_pkg.
module tkcr_cell (
   input  logic                               clock,
   input  logic [tkcr_pkg::MODE_BITS-1:0]     metric_mode,
   input  tkcr_pkg::cell_ctl_type             ctl,
   input  tkcr_pkg::entry_type                cand,
   input  tkcr_pkg::entry_type                left_entry,
   input  tkcr_pkg::entry_type                right_entry,
   input  logic                               bt_left,
   output tkcr_pkg::entry_type                entry,
   output logic                               beaten,
   output logic                               bt_out
);
   import tkcr_pkg::*;

   entry_type entry_ff, entry_in;

   // The candidate belongs at or before this cell once it beats the entry here or any entry
   // further left, or when this cell is the free or evicted slot at the end of the sorted run.
   // Carrying the left flag along keeps the first winning slot correct even when the held
   // entries were sorted under an earlier metric.
   assign beaten = ranks_above(metric_mode, cand, entry_ff);
   assign bt_out = bt_left || beaten || ctl.at_last;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         CELL_OFFER: begin
            if (ctl.in_range) begin
               if (bt_left) begin
                  entry_in = left_entry;
               end else if (bt_out) begin
                  entry_in = cand;
               end
            end
         end
         CELL_SHIFT: entry_in = right_entry;
         default:    entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/top_k_candidate_retention_top.sv =====
// Top level of the top-k candidate retention block: candidate stage, cell chain, drain control.
// Depends on tkcr_pkg, tkcr_prep, tkcr_cell and top_k_candidate_retention_top_defines.svh.
//
//   Channel   Ports                               Handshake
//   --------  ----------------------------------  --------------------------------------
//   request   start, busy, req_item               accepted when start is high, busy low
//   result    rsp_strobe, rsp_item                marked by strobe, cannot be held off
//   config    csr_valid, csr_ready, csr_index,    written when csr_valid and csr_ready
//             csr_data
//
// An offer is registered in the candidate stage and then in the cell chain; a new offer is
// taken every cycle while busy is low, so offers stream at one item per clock outside a drain.
// A drain holds busy high while it emits one result item per cycle as the chain shifts its
// head entry out, until the store is empty; an empty store yields one item marked empty.
// Reset is synchronous and active high; it empties the store and restores the registers to
// composite metric and a limit of 16. The receiver of results has no way to stall the block.
`include "top_k_candidate_retention_top_defines.svh"

module top_k_candidate_retention_top #(
   parameter int KEEP_DEPTH = tkcr_pkg::KEEP_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  tkcr_pkg::req_type                     req_item,
   output logic                                  rsp_strobe,
   output tkcr_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tkcr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [tkcr_pkg::LIMIT_BITS-1:0]       csr_data
);
   import tkcr_pkg::*;

   // The count must be able to hold the depth itself.
   localparam int CW = $clog2(KEEP_DEPTH + 1);
   localparam int LW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

   // Configuration registers.
   logic [MODE_BITS-1:0]  mode_ff, mode_in;
   logic [LIMIT_BITS-1:0] limit_ff, limit_in;

   // Control state.
   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  item_go;
   entry_type             cand;
   logic                  cand_valid;

   logic [LW-1:0]         lim;
   logic                  below;
   logic                  worst_beaten;
   logic                  offer_go;
   logic                  drain_shift;
   logic [CW-1:0]         last_pos;

   entry_type             entry_w [KEEP_DEPTH];
   cell_ctl_type          ctl_w   [KEEP_DEPTH];
   logic [KEEP_DEPTH-1:0] beaten_w;
   logic [KEEP_DEPTH-1:0] tail_w;
   logic [KEEP_DEPTH-1:0] bt_w;

   assign csr_ready = 1'b1;
   assign item_go   = start && !busy;

   always_comb begin
      mode_in  = mode_ff;
      limit_in = limit_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_METRIC_MODE: mode_in  = csr_data[MODE_BITS-1:0];
            CSR_KEEP_LIMIT:  limit_in = csr_data;
            default: begin
               mode_in  = mode_ff;
               limit_in = limit_ff;
            end
         endcase
      end
   end

   tkcr_prep u_prep (
      .clock      (clock),
      .reset      (reset),
      .load       (item_go && (req_item.opcode == OP_OFFER)),
      .item       (req_item),
      .cand       (cand),
      .cand_valid (cand_valid)
   );

   // A limit above the chain depth acts as the depth.
   always_comb begin
      lim = (LW'(limit_ff) > LW'(KEEP_DEPTH)) ? LW'(KEEP_DEPTH) : LW'(limit_ff);
   end

   assign below        = LW'(count_ff) < lim;
   assign worst_beaten = |(beaten_w & tail_w);

   // Below the limit the candidate always goes in; at or over it, it must beat the last entry,
   // which it then evicts. A limit of zero takes nothing.
   assign offer_go = cand_valid && (lim != '0) &&
                     (below || ((count_ff != '0) && worst_beaten));
   assign last_pos = below ? count_ff : CW'(count_ff - 1'b1);

   for (genvar i = 0; i < KEEP_DEPTH; i++) begin : g_cell
      assign tail_w[i]         = (count_ff == CW'(i + 1));
      assign ctl_w[i].op       = drain_shift ? CELL_SHIFT : (offer_go ? CELL_OFFER : CELL_HOLD);
      assign ctl_w[i].in_range = (CW'(i) <= last_pos);
      assign ctl_w[i].at_last  = (CW'(i) == last_pos);

      if (i == 0) begin : g_head
         tkcr_cell u_cell (
            .clock       (clock),
            .metric_mode (mode_ff),
            .ctl         (ctl_w[i]),
            .cand        (cand),
            .left_entry  (entry_w[i]),
            .right_entry ((KEEP_DEPTH > 1) ? entry_w[(KEEP_DEPTH > 1) ? 1 : 0] : entry_w[i]),
            .bt_left     (1'b0),
            .entry       (entry_w[i]),
            .beaten      (beaten_w[i]),
            .bt_out      (bt_w[i])
         );
      end else if (i == KEEP_DEPTH - 1) begin : g_tail
         tkcr_cell u_cell (
            .clock       (clock),
            .metric_mode (mode_ff),
            .ctl         (ctl_w[i]),
            .cand        (cand),
            .left_entry  (entry_w[i-1]),
            .right_entry (entry_w[i]),
            .bt_left     (bt_w[i-1]),
            .entry       (entry_w[i]),
            .beaten      (beaten_w[i]),
            .bt_out      (bt_w[i])
         );
      end else begin : g_mid
         tkcr_cell u_cell (
            .clock       (clock),
            .metric_mode (mode_ff),
            .ctl         (ctl_w[i]),
            .cand        (cand),
            .left_entry  (entry_w[i-1]),
            .right_entry (entry_w[i+1]),
            .bt_left     (bt_w[i-1]),
            .entry       (entry_w[i]),
            .beaten      (beaten_w[i]),
            .bt_out      (bt_w[i])
         );
      end
   end

   // Next state of the drain sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (item_go && (req_item.opcode == OP_DRAIN)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (count_ff <= CW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Drain sequencer outputs: emit and shift out the head cell, or mark an empty store.
   always_comb begin
      busy          = 1'b0;
      drain_shift   = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_DRAIN: begin
            busy          = 1'b1;
            rsp_strobe_in = 1'b1;
            if (count_ff == '0) begin
               rsp_in.store_empty = 1'b1;
               rsp_in.last_entry  = 1'b1;
            end else begin
               drain_shift            = 1'b1;
               rsp_in.out_numerator   = entry_w[0].num;
               rsp_in.out_denominator = entry_w[0].den;
               rsp_in.out_rank_score  = entry_w[0].rank;
               rsp_in.out_power_score = entry_w[0].power;
               rsp_in.out_held_rank   = entry_w[0].hrank;
               rsp_in.out_held_power  = entry_w[0].hpower;
               rsp_in.last_entry      = (count_ff == CW'(1));
            end
         end
         default: busy = 1'b0;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (drain_shift) begin
         count_in = CW'(count_ff - 1'b1);
      end else if (offer_go && below) begin
         count_in = CW'(count_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_RESET;
         limit_ff      <= LIMIT_RESET;
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         limit_ff      <= limit_in;
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // The store never holds more entries than the chain has cells.
   `TKCR_ASSERT_IMPLIES(a_count_bound, 1'b1, count_ff <= CW'(KEEP_DEPTH))
   // An offer still in the candidate stage never overlaps a drain.
   `TKCR_ASSERT_IMPLIES(a_no_offer_in_drain, state_ff == ST_DRAIN, !cand_valid)
   // The final drain cycle marks its item as last and leaves the store empty.
   `TKCR_ASSERT_NEXT(a_drain_final, (state_ff == ST_DRAIN) && (count_ff <= CW'(1)), rsp_strobe && rsp_item.last_entry && (state_ff == ST_IDLE) && (count_ff == '0))
   // Earlier drain cycles emit unmarked items and retire one entry each.
   `TKCR_ASSERT_NEXT(a_drain_step, (state_ff == ST_DRAIN) && (count_ff > CW'(1)), rsp_strobe && !rsp_item.last_entry && (count_ff == CW'($past(count_ff) - 1'b1)))
   // An accepted offer below the limit grows the store by one.
   `TKCR_ASSERT_NEXT(a_offer_grows, offer_go && below, count_ff == CW'($past(count_ff) + 1'b1))

endmodule
